/* hw/rtl/round_robin_process_scheduler_assert.svh */
// Assertion macros shared by the scheduler modules.
// Every macro samples on the rising edge of clock and is off while reset is high.
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_ASSERT_SVH

// A property that holds at every edge outside reset.
`define RRPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A cause seen at one edge requires an effect at the next edge.
`define RRPS_ASSERT_NEXT(lbl, cause, effect, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

/* hw/rtl/rrps_pkg.sv */
package rrps_pkg;

   localparam int IdWidth      = 16;
   localparam int ArrivalWidth = 24;
   localparam int DemandWidth  = 16;
   localparam int TimeWidth    = 32;
   localparam int DiffWidth    = 33;
   localparam int SumWidth     = 48;
   localparam int CountWidth   = 32;

   localparam logic [DemandWidth-1:0] QuantumReset = 16'd4;

   // Codes of the mode field of a request beat.
   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   // One ready-queue entry as it is kept in memory.
   typedef struct packed {
      logic [IdWidth-1:0]      id;
      logic [ArrivalWidth-1:0] arrival;
      logic [DemandWidth-1:0]  demand;
      logic [DemandWidth-1:0]  remaining;
   } entry_type;

   localparam int EntryWidth = $bits(entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic enqueue;
      logic tick_commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
      logic slice_done;
      logic out_free;
   } status_type;

endpackage

/* hw/rtl/rrps_if.sv */
// Request channel: a new process or one tick of time.
interface rrps_req_if;
   logic                               valid;
   logic                               ready;
   logic                               mode;
   logic [rrps_pkg::IdWidth-1:0]       proc_id;
   logic [rrps_pkg::ArrivalWidth-1:0]  arrival_time;
   logic [rrps_pkg::DemandWidth-1:0]   burst_ticks;

   modport source (output valid, mode, proc_id, arrival_time, burst_ticks, input ready);
   modport sink   (input valid, mode, proc_id, arrival_time, burst_ticks, output ready);
endinterface

// Response channel: one beat for every slice that ends.
interface rrps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rrps_pkg::IdWidth-1:0]        slice_process;
   logic                                finished;
   logic [rrps_pkg::TimeWidth-1:0]      slice_start;
   logic [rrps_pkg::TimeWidth-1:0]      slice_end;
   logic signed [rrps_pkg::DiffWidth-1:0] turnaround;
   logic signed [rrps_pkg::DiffWidth-1:0] waiting;
   logic signed [rrps_pkg::SumWidth-1:0]  sum_turnaround;
   logic signed [rrps_pkg::SumWidth-1:0]  sum_waiting;
   logic [rrps_pkg::CountWidth-1:0]     retired_count;

   modport source (output valid, slice_process, finished, slice_start, slice_end, turnaround,
                   waiting, sum_turnaround, sum_waiting, retired_count, input ready);
   modport sink   (input valid, slice_process, finished, slice_start, slice_end, turnaround,
                   waiting, sum_turnaround, sum_waiting, retired_count, output ready);
endinterface

/* hw/rtl/rrps_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
module rrps_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rrps_controller.sv */
// Sequencer: takes request beats and steps one tick through its evaluation.
module rrps_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   output logic                 req_ready,
   input  rrps_pkg::status_type status,
   output rrps_pkg::cmd_type    cmd
);
   import rrps_pkg::*;

   `include "round_robin_process_scheduler_assert.svh"

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      accept;

   assign accept = ready_ff && req_valid;

   always_comb begin
      state_in        = state_ff;
      cmd.enqueue     = 1'b0;
      cmd.tick_commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_ENQUEUE) begin
               // A full queue drops the beat without a trace.
               cmd.enqueue = !status.full;
            end else if (accept && req_mode == MODE_TICK && !status.empty) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // Hold the tick while a finished slice has no room in the output register.
            if (!status.slice_done || status.out_free) begin
               cmd.tick_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

   `RRPS_ASSERT(a_ready_only_idle, (!ready_ff || state_ff == ST_IDLE),
                "request ready outside the idle state")
   `RRPS_ASSERT_NEXT(a_eval_leaves, (state_ff == ST_EVAL && status.out_free),
                     (state_ff == ST_IDLE && ready_ff), "tick evaluation did not complete")

endmodule

/* hw/rtl/rrps_datapath.sv */
// Queue pointers, timing counters, running totals and the response register.
module rrps_datapath #(
   parameter int QUEUE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rrps_pkg::DemandWidth-1:0]    csr_wr_data,
   input  logic [rrps_pkg::IdWidth-1:0]        req_proc_id,
   input  logic [rrps_pkg::ArrivalWidth-1:0]   req_arrival_time,
   input  logic [rrps_pkg::DemandWidth-1:0]    req_burst_ticks,
   input  rrps_pkg::cmd_type                   cmd,
   output rrps_pkg::status_type                status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rrps_pkg::IdWidth-1:0]        rsp_slice_process,
   output logic                                rsp_finished,
   output logic [rrps_pkg::TimeWidth-1:0]      rsp_slice_start,
   output logic [rrps_pkg::TimeWidth-1:0]      rsp_slice_end,
   output logic signed [rrps_pkg::DiffWidth-1:0] rsp_turnaround,
   output logic signed [rrps_pkg::DiffWidth-1:0] rsp_waiting,
   output logic signed [rrps_pkg::SumWidth-1:0]  rsp_sum_turnaround,
   output logic signed [rrps_pkg::SumWidth-1:0]  rsp_sum_waiting,
   output logic [rrps_pkg::CountWidth-1:0]     rsp_retired_count
);
   import rrps_pkg::*;

   `include "round_robin_process_scheduler_assert.svh"

   localparam int IdxWidth = $clog2(QUEUE_DEPTH);
   localparam int OccWidth = $clog2(QUEUE_DEPTH + 1);

   logic [IdxWidth-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [OccWidth-1:0]    occ_ff, occ_in;
   logic [DemandWidth-1:0] quantum_ff;
   // Slice length and elapsed time as they will stand once the pending tick counts.
   logic [DemandWidth-1:0] slice_inc_ff, slice_inc_in;
   logic [TimeWidth-1:0]   time_ff, time_in;
   logic [SumWidth-1:0]    sum_turn_ff, sum_turn_in, sum_wait_ff, sum_wait_in;
   logic [CountWidth-1:0]  done_ff, done_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   entry_type              rd_entry, wr_entry;
   logic                   wr_en;
   logic                   slice_done, fin, load_rsp;
   logic [SumWidth-1:0]    turn_wide, wait_wide;
   logic [IdxWidth:0]      tail_sum, tail_expect;

   function automatic logic [IdxWidth-1:0] next_index(input logic [IdxWidth-1:0] idx);
      return (idx == IdxWidth'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   rrps_ram #(
      .Width(EntryWidth),
      .Depth(QUEUE_DEPTH)
   ) u_queue_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tail_ff),
      .wr_data(wr_entry),
      .rd_addr(head_ff),
      .rd_data(rd_entry)
   );

   // A slice runs on while it is short of both the quantum and the head's remaining time.
   assign slice_done = !((slice_inc_ff < quantum_ff) && (slice_inc_ff < rd_entry.remaining));
   assign fin        = rd_entry.remaining <= slice_inc_ff;

   // Turnaround and waiting time in the width of the running sums.
   assign turn_wide = {{(SumWidth-TimeWidth){1'b0}}, time_ff}
                    - {{(SumWidth-ArrivalWidth){1'b0}}, rd_entry.arrival};
   assign wait_wide = turn_wide - {{(SumWidth-DemandWidth){1'b0}}, rd_entry.demand};

   assign load_rsp = cmd.tick_commit && slice_done;
   assign wr_en    = cmd.enqueue || (load_rsp && !fin);

   always_comb begin
      if (cmd.enqueue) begin
         wr_entry = '{id: req_proc_id, arrival: req_arrival_time,
                      demand: req_burst_ticks, remaining: req_burst_ticks};
      end else begin
         wr_entry = '{id: rd_entry.id, arrival: rd_entry.arrival, demand: rd_entry.demand,
                      remaining: rd_entry.remaining - slice_inc_ff};
      end
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      slice_inc_in = slice_inc_ff;
      time_in      = time_ff;
      sum_turn_in  = sum_turn_ff;
      sum_wait_in  = sum_wait_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.enqueue) begin
         tail_in = next_index(tail_ff);
         occ_in  = occ_ff + 1'b1;
      end
      if (cmd.tick_commit) begin
         time_in      = time_ff + 1'b1;
         slice_inc_in = slice_done ? DemandWidth'(1) : slice_inc_ff + 1'b1;
      end
      if (load_rsp) begin
         head_in      = next_index(head_ff);
         rsp_valid_in = 1'b1;
         if (fin) begin
            occ_in      = occ_ff - 1'b1;
            sum_turn_in = sum_turn_ff + turn_wide;
            sum_wait_in = sum_wait_ff + wait_wide;
            done_in     = done_ff + 1'b1;
         end else begin
            tail_in = next_index(tail_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         quantum_ff   <= QuantumReset;
         slice_inc_ff <= DemandWidth'(1);
         time_ff      <= TimeWidth'(1);
         sum_turn_ff  <= '0;
         sum_wait_ff  <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         slice_inc_ff <= slice_inc_in;
         time_ff      <= time_in;
         sum_turn_ff  <= sum_turn_in;
         sum_wait_ff  <= sum_wait_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            quantum_ff <= csr_wr_data;
         end
      end
   end

   // Response payload; loaded only when a slice ends.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_slice_process  <= rd_entry.id;
         rsp_finished       <= fin;
         rsp_slice_start    <= time_ff - {{(TimeWidth-DemandWidth){1'b0}}, slice_inc_ff};
         rsp_slice_end      <= time_ff;
         rsp_turnaround     <= fin ? signed'(turn_wide[DiffWidth-1:0]) : '0;
         rsp_waiting        <= fin ? signed'(wait_wide[DiffWidth-1:0]) : '0;
         rsp_sum_turnaround <= signed'(sum_turn_in);
         rsp_sum_waiting    <= signed'(sum_wait_in);
         rsp_retired_count  <= done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign status.empty      = (occ_ff == '0);
   assign status.full       = (occ_ff == OccWidth'(QUEUE_DEPTH));
   assign status.slice_done = slice_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // Where the tail must stand given head and occupancy, for the check below.
   assign tail_sum    = (IdxWidth + 1)'(head_ff) + (IdxWidth + 1)'(occ_ff);
   assign tail_expect = (tail_sum >= (IdxWidth + 1)'(QUEUE_DEPTH))
                      ? tail_sum - (IdxWidth + 1)'(QUEUE_DEPTH) : tail_sum;

   `RRPS_ASSERT(a_tail_tracks_occ, (tail_expect[IdxWidth-1:0] == tail_ff),
                "tail pointer out of step with head and occupancy")
   `RRPS_ASSERT_NEXT(a_slice_end_loads, (load_rsp),
                     (rsp_valid_ff && slice_inc_ff == DemandWidth'(1)),
                     "ended slice did not reach the response register")

endmodule

/* hw/rtl/round_robin_process_scheduler.sv */
// Enqueue beat: the entry is written at the tail at the accepting edge.
// Tick beat: a head read from the queue RAM and then evaluate and commit; an
// ended slice, requeued or retired, shows on the response port right after the commit.
// Commit of an ended slice waits while the response register holds a beat not yet taken.
// Throughput: one enqueue per cycle; no new beat is taken until a tick has committed.
// Synchronous reset clears pointers, occupancy, totals, count; time is 1, quantum 4.
module round_robin_process_scheduler #(
   parameter int QUEUE_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   rrps_req_if.sink                         req_if,
   rrps_rsp_if.source                       rsp_if,
   input  logic                             csr_wr_en,
   input  logic [rrps_pkg::DemandWidth-1:0] csr_wr_data
);
   import rrps_pkg::*;

   // The controller and the datapath talk only through these two bundles.
   cmd_type    cmd;
   status_type status;

   // The controller owns the request handshake. A tick is accepted in the idle state,
   // and the head entry that the RAM returns is evaluated in the state after it. When the
   // slice ends and the response register still holds a beat that has not been taken,
   // the tick waits there; otherwise it commits and the block is ready again.
   rrps_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_if.valid),
      .req_mode (req_if.mode),
      .req_ready(req_if.ready),
      .status   (status),
      .cmd      (cmd)
   );

   // The datapath keeps the circular queue in a RAM read at the head and written at
   // the tail. A requeued process goes back to the tail with its remaining time reduced
   // by the slice; a retired one updates the running turnaround and waiting totals.
   // The response register decouples the result beat from the next request.
   rrps_datapath #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_proc_id       (req_if.proc_id),
      .req_arrival_time  (req_if.arrival_time),
      .req_burst_ticks   (req_if.burst_ticks),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .rsp_slice_process (rsp_if.slice_process),
      .rsp_finished      (rsp_if.finished),
      .rsp_slice_start   (rsp_if.slice_start),
      .rsp_slice_end     (rsp_if.slice_end),
      .rsp_turnaround    (rsp_if.turnaround),
      .rsp_waiting       (rsp_if.waiting),
      .rsp_sum_turnaround(rsp_if.sum_turnaround),
      .rsp_sum_waiting   (rsp_if.sum_waiting),
      .rsp_retired_count (rsp_if.retired_count)
   );

endmodule
